FILE: rtl/servo_pulse_position_decoder_unit_assert.svh
// Assertion macros shared by the servo pulse decoder RTL.
`ifndef SERVO_PULSE_POSITION_DECODER_UNIT_ASSERT_SVH
`define SERVO_PULSE_POSITION_DECODER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPPD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("servo pulse decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("servo pulse decoder check failed");

`endif

FILE: rtl/sppd_pkg.sv
`default_nettype none

package sppd_pkg;

    localparam int POS_W      = 14;
    localparam int DUR_W      = 16;
    localparam int SHIFT_W    = 4;
    localparam int TICK_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [SHIFT_W-1:0] MAX_SHIFT = 4'd8;
    localparam logic [POS_W-1:0]   POS_MAX   = 14'h3FFF;
    localparam logic [TICK_W-1:0]  TICK_MAX  = 8'hFF;

    localparam logic [DUR_W-1:0]   RST_MIN_DURATION   = 16'd1000;
    localparam logic [DUR_W-1:0]   RST_MAX_DURATION   = 16'd5000;
    localparam logic [POS_W-1:0]   RST_MIN_POSITION   = 14'd1638;
    localparam logic [POS_W-1:0]   RST_MAX_POSITION   = 14'd4502;
    localparam logic [SHIFT_W-1:0] RST_FILTER_SHIFT   = 4'd3;
    localparam logic [TICK_W-1:0]  RST_TIMEOUT_TICKS  = 8'd50;
    localparam logic [POS_W-1:0]   RST_START_POSITION = 14'd3022;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DURATION   = 3'd0,
        CFG_MAX_DURATION   = 3'd1,
        CFG_MIN_POSITION   = 3'd2,
        CFG_MAX_POSITION   = 3'd3,
        CFG_FILTER_SHIFT   = 3'd4,
        CFG_TIMEOUT_TICKS  = 3'd5,
        CFG_START_POSITION = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic pin_level;
        logic slow_tick;
    } in_t;

    typedef struct packed {
        logic             position_valid;
        logic [POS_W-1:0] seek_position;
        logic             drive_enabled;
        logic             pulse_rejected;
    } out_t;

endpackage

`default_nettype wire

FILE: rtl/servo_pulse_position_decoder_unit.sv
// Servo pulse position decoder.
// The input channel (in_valid, in_stall, in_data) carries one sample of the
// command pin per transfer, with a flag for each slow timebase tick. Every
// input transfer yields exactly one output transfer (out_valid, out_stall,
// out_data) with the current filtered seek position, the drive enable and
// flags for a newly accepted or a rejected pulse.
// The sample is registered, then one pass of logic updates the width counter,
// the window check, scale and clamp, the low-pass filter and the idle timeout,
// and writes the result register. A result passes through the sample register
// and the result register before it is offered; one item is taken every cycle
// while the receiver keeps up, and the per-item state update is the only loop.
// When the receiver stalls, a one-entry skid register catches the next result,
// and in_stall rises only once both the sample and skid registers are full.
// Reset restores all configuration registers to their defaults, clears the
// pulse and timeout state, disables drive and preloads the filter with the
// default start position. Configuration writes take effect at once; the user
// must make them only while no transfer is in flight; the block does not check.

`default_nettype none

`include "servo_pulse_position_decoder_unit_assert.svh"

module servo_pulse_position_decoder_unit #(
    parameter int WIDTH_BITS = 16,
    parameter int ACC_BITS   = 24
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output      logic                                in_stall,
    input  wire sppd_pkg::in_t                       in_data,
    output      logic                                out_valid,
    input  wire logic                                out_stall,
    output      sppd_pkg::out_t                      out_data,
    input  wire logic                                cfg_en,
    input  wire logic [sppd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sppd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sppd_pkg::*;

    localparam int SUM_W  = (WIDTH_BITS + 1 > POS_W) ? WIDTH_BITS + 1 : POS_W;
    localparam int CMP_W  = (WIDTH_BITS > DUR_W) ? WIDTH_BITS : DUR_W;
    localparam int WIDE_W = (ACC_BITS > POS_W + 8) ? ACC_BITS : POS_W + 8;
    localparam logic [ACC_BITS-1:0] ACC_RESET =
        ACC_BITS'(RST_START_POSITION) << RST_FILTER_SHIFT;

    logic [DUR_W-1:0]   min_dur_reg;
    logic [DUR_W-1:0]   max_dur_reg;
    logic [POS_W-1:0]   min_pos_reg;
    logic [POS_W-1:0]   max_pos_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [TICK_W-1:0]  timeout_reg;

    logic [WIDTH_BITS-1:0] wcnt_reg, wcnt_next;
    logic                  measuring_reg, measuring_next;
    logic                  prev_level_reg, prev_level_next;
    logic [ACC_BITS-1:0]   acc_reg, acc_next;
    logic [POS_W-1:0]      pos_out_reg, pos_out_next;
    logic [TICK_W-1:0]     idle_reg, idle_next;
    logic                  drive_on_reg, drive_on_next;

    in_t  s1_reg;
    logic s1_valid_reg, s1_valid_next;
    out_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;
    out_t skid_reg;
    logic skid_valid_reg, skid_valid_next;

    logic in_accept;
    logic move;
    logic out_take;
    out_t result;

    logic [SHIFT_W-1:0]  k;
    logic                rise;
    logic                ended;
    logic                in_window;
    logic [SUM_W-1:0]    sum_w;
    logic [SUM_W-1:0]    pos_lo;
    logic [SUM_W-1:0]    pos_hi;
    logic [POS_W-1:0]    pos_clamped;
    logic [ACC_BITS:0]   acc_sum;
    logic [ACC_BITS-1:0] acc_filt;
    logic [ACC_BITS-1:0] filt_out;
    logic [POS_W-1:0]    filt_sat;
    logic [WIDE_W-1:0]   preload_wide;
    logic [ACC_BITS-1:0] preload_acc;
    logic                cfg_start;

    assign in_accept = in_valid && !in_stall;
    assign move      = s1_valid_reg && !skid_valid_reg;
    assign in_stall  = s1_valid_reg && skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_start = cfg_en && (cfg_index_t'(cfg_index) == CFG_START_POSITION);

    always_comb
    begin
        k = (shift_reg > MAX_SHIFT) ? MAX_SHIFT : shift_reg;
        preload_wide = WIDE_W'(cfg_data[POS_W-1:0]) << k;
        if ((preload_wide >> ACC_BITS) != '0)
        begin
            preload_acc = '1;
        end
        else
        begin
            preload_acc = ACC_BITS'(preload_wide);
        end
    end

    always_comb
    begin
        rise      = s1_reg.pin_level && !prev_level_reg;
        ended     = !s1_reg.pin_level && prev_level_reg && measuring_reg;
        in_window = (CMP_W'(wcnt_reg) > CMP_W'(min_dur_reg)) &&
                    (CMP_W'(wcnt_reg) < CMP_W'(max_dur_reg));

        sum_w  = SUM_W'(wcnt_reg) + SUM_W'(wcnt_reg >> 4);
        pos_lo = (sum_w < SUM_W'(min_pos_reg)) ? SUM_W'(min_pos_reg) : sum_w;
        pos_hi = (pos_lo > SUM_W'(max_pos_reg)) ? SUM_W'(max_pos_reg) : pos_lo;
        pos_clamped = POS_W'(pos_hi);

        acc_sum  = {1'b0, acc_reg} - {1'b0, acc_reg >> k} + (ACC_BITS + 1)'(pos_clamped);
        acc_filt = acc_sum[ACC_BITS] ? '1 : acc_sum[ACC_BITS-1:0];
        filt_out = acc_filt >> k;
        filt_sat = (filt_out > ACC_BITS'(POS_MAX)) ? POS_MAX : POS_W'(filt_out);

        wcnt_next      = wcnt_reg;
        measuring_next = measuring_reg;
        acc_next       = acc_reg;
        pos_out_next   = pos_out_reg;
        drive_on_next  = drive_on_reg;
        result.position_valid = 1'b0;
        result.pulse_rejected = 1'b0;

        if (rise)
        begin
            measuring_next = 1'b1;
            wcnt_next      = WIDTH_BITS'(1);
        end
        else if (s1_reg.pin_level)
        begin
            if (measuring_reg && (wcnt_reg != '1))
            begin
                wcnt_next = wcnt_reg + WIDTH_BITS'(1);
            end
        end
        else if (ended)
        begin
            measuring_next = 1'b0;
            if (in_window)
            begin
                acc_next     = acc_filt;
                pos_out_next = filt_sat;
                result.position_valid = 1'b1;
            end
            else
            begin
                result.pulse_rejected = 1'b1;
            end
        end
        prev_level_next = s1_reg.pin_level;

        idle_next = idle_reg;
        if (s1_reg.slow_tick && (idle_reg != TICK_MAX))
        begin
            idle_next = idle_reg + TICK_W'(1);
        end
        if (result.position_valid)
        begin
            drive_on_next = 1'b1;
            idle_next     = '0;
        end
        else if (!ended && (idle_next > timeout_reg))
        begin
            drive_on_next = 1'b0;
            idle_next     = '0;
        end

        result.seek_position = pos_out_next;
        result.drive_enabled = drive_on_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dur_reg <= RST_MIN_DURATION;
            max_dur_reg <= RST_MAX_DURATION;
            min_pos_reg <= RST_MIN_POSITION;
            max_pos_reg <= RST_MAX_POSITION;
            shift_reg   <= RST_FILTER_SHIFT;
            timeout_reg <= RST_TIMEOUT_TICKS;
        end
        else if (cfg_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MIN_DURATION:  min_dur_reg <= cfg_data;
                CFG_MAX_DURATION:  max_dur_reg <= cfg_data;
                CFG_MIN_POSITION:  min_pos_reg <= cfg_data[POS_W-1:0];
                CFG_MAX_POSITION:  max_pos_reg <= cfg_data[POS_W-1:0];
                CFG_FILTER_SHIFT:  shift_reg   <= cfg_data[SHIFT_W-1:0];
                CFG_TIMEOUT_TICKS: timeout_reg <= cfg_data[TICK_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcnt_reg       <= '0;
            measuring_reg  <= 1'b0;
            prev_level_reg <= 1'b0;
            acc_reg        <= ACC_RESET;
            pos_out_reg    <= RST_START_POSITION;
            idle_reg       <= '0;
            drive_on_reg   <= 1'b0;
        end
        else if (cfg_start)
        begin
            acc_reg     <= preload_acc;
            pos_out_reg <= cfg_data[POS_W-1:0];
        end
        else if (move)
        begin
            wcnt_reg       <= wcnt_next;
            measuring_reg  <= measuring_next;
            prev_level_reg <= prev_level_next;
            acc_reg        <= acc_next;
            pos_out_reg    <= pos_out_next;
            idle_reg       <= idle_next;
            drive_on_reg   <= drive_on_next;
        end
    end

    always_comb
    begin
        s1_valid_next   = in_accept || (s1_valid_reg && !move);
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        if (move)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg <= in_data;
        end
        out_reg <= out_next;
        if (move && out_valid_reg && !out_take)
        begin
            skid_reg <= result;
        end
    end

    `SPPD_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `SPPD_ASSERT_SAME(a_flags_exclusive, out_valid_reg,
        !(out_reg.position_valid && out_reg.pulse_rejected))
    `SPPD_ASSERT_NEXT(a_valid_pulse_drives, move && result.position_valid && !cfg_start,
        drive_on_reg && (idle_reg == '0))
    `SPPD_ASSERT_NEXT(a_stalled_result_to_skid, move && out_valid_reg && out_stall,
        skid_valid_reg)

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import sppd_pkg::*;

    localparam int CNT_W       = 16;
    localparam int ACC_W       = 24;
    localparam logic [ACC_W:0] ACC_MAX = (25'd1 << ACC_W) - 25'd1;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        cfg_index_t reg_idx;
        int         reg_val;
        logic       pin;
        logic       tick;
        int         reps;
        bit         fixed;
        out_t       lit;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;
    logic cfg_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Register copies held by the predictor.
    logic [DUR_W-1:0] dur_lo, dur_hi;
    logic [POS_W-1:0] pos_lo, pos_hi, start_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [TICK_W-1:0] tmo_reg;

    // Decoder state held by the predictor.
    logic [CNT_W-1:0] pulse_len;
    logic in_pulse, last_pin, drive;
    logic [ACC_W-1:0] filt_acc;
    logic [POS_W-1:0] seek;
    logic [TICK_W-1:0] idle_cnt;

    out_t pending_outputs[$];
    bit idle_on = 1'b1;
    int n_errors = 0;
    int n_samples = 0;
    int n_outputs = 0;
    int n_writes = 0;
    int n_positions = 0;
    int n_rejects = 0;
    int n_drops = 0;
    int cycle_count = 0;
    int stall_left = 0;

    servo_pulse_position_decoder_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_en(cfg_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_gap();
        int r;
        if (!idle_on)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return 0;
        end
        if (r < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [SHIFT_W-1:0] eff_shift();
        return (shift_reg > MAX_SHIFT) ? MAX_SHIFT : shift_reg;
    endfunction

    function automatic void load_start_position();
        logic [31:0] pre;
        pre = 32'(start_reg) << eff_shift();
        filt_acc = (pre > 32'(ACC_MAX)) ? ACC_MAX[ACC_W-1:0] : pre[ACC_W-1:0];
        seek = start_reg;
    endfunction

    function automatic out_t decode_sample(in_t smp);
        logic ended, fresh, bad;
        logic [CNT_W:0] scaled;
        logic [ACC_W:0] mix;
        logic [ACC_W-1:0] filt;
        logic [SHIFT_W-1:0] k;
        out_t res;
        ended = 1'b0;
        fresh = 1'b0;
        bad = 1'b0;
        k = eff_shift();
        if (smp.pin_level && !last_pin)
        begin
            in_pulse = 1'b1;
            pulse_len = CNT_W'(1);
        end
        else if (smp.pin_level)
        begin
            if (in_pulse && pulse_len != '1)
            begin
                pulse_len = pulse_len + 1'b1;
            end
        end
        else if (last_pin && in_pulse)
        begin
            ended = 1'b1;
            in_pulse = 1'b0;
            if (pulse_len > dur_lo && pulse_len < dur_hi)
            begin
                scaled = {1'b0, pulse_len} + (pulse_len >> 4);
                if (scaled < pos_lo)
                begin
                    scaled = (CNT_W + 1)'(pos_lo);
                end
                if (scaled > pos_hi)
                begin
                    scaled = (CNT_W + 1)'(pos_hi);
                end
                mix = {1'b0, filt_acc} - (filt_acc >> k) + scaled;
                filt_acc = (mix > ACC_MAX) ? ACC_MAX[ACC_W-1:0] : mix[ACC_W-1:0];
                filt = filt_acc >> k;
                seek = (filt > POS_MAX) ? POS_MAX : filt[POS_W-1:0];
                fresh = 1'b1;
                n_positions++;
            end
            else
            begin
                bad = 1'b1;
                n_rejects++;
            end
        end
        last_pin = smp.pin_level;
        if (smp.slow_tick && idle_cnt != TICK_MAX)
        begin
            idle_cnt = idle_cnt + 1'b1;
        end
        if (fresh)
        begin
            drive = 1'b1;
            idle_cnt = '0;
        end
        else if (!ended && idle_cnt > tmo_reg)
        begin
            if (drive)
            begin
                n_drops++;
            end
            drive = 1'b0;
            idle_cnt = '0;
        end
        res.position_valid = fresh;
        res.seek_position = seek;
        res.drive_enabled = drive;
        res.pulse_rejected = bad;
        return res;
    endfunction

    function automatic row_t sample_row(logic pin, logic tick, int reps);
        row_t r;
        r.kind = ROW_SAMPLE;
        r.reg_idx = CFG_MIN_DURATION;
        r.reg_val = 0;
        r.pin = pin;
        r.tick = tick;
        r.reps = reps;
        r.fixed = 1'b0;
        r.lit = '0;
        return r;
    endfunction

    function automatic row_t checked_row(logic pin, logic tick, int reps,
                                         logic pv, int pos, logic de, logic pr);
        row_t r;
        r = sample_row(pin, tick, reps);
        r.fixed = 1'b1;
        r.lit.position_valid = pv;
        r.lit.seek_position = 14'(pos);
        r.lit.drive_enabled = de;
        r.lit.pulse_rejected = pr;
        return r;
    endfunction

    function automatic row_t write_row(cfg_index_t idx, int val);
        row_t r;
        r = sample_row(1'b0, 1'b0, 0);
        r.kind = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("tb_top: MISMATCH output %0d: %s", n_outputs, msg);
        n_errors++;
    endtask

    task automatic send_sample(input logic pin, input logic tick, input bit fixed,
                               input out_t lit);
        in_t smp;
        out_t guess;
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp.pin_level = pin;
        smp.slow_tick = tick;
        guess = decode_sample(smp);
        pending_outputs.push_back(fixed ? lit : guess);
        in_valid <= 1'b1;
        in_data <= smp;
        n_samples++;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
    endtask

    task automatic drain_outputs();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_outputs.size() != 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int val);
        logic [CFG_DATA_W-1:0] word;
        word = val[CFG_DATA_W-1:0];
        cfg_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= word;
        case (idx)
            CFG_MIN_DURATION: dur_lo = word;
            CFG_MAX_DURATION: dur_hi = word;
            CFG_MIN_POSITION: pos_lo = word[POS_W-1:0];
            CFG_MAX_POSITION: pos_hi = word[POS_W-1:0];
            CFG_FILTER_SHIFT: shift_reg = word[SHIFT_W-1:0];
            CFG_TIMEOUT_TICKS: tmo_reg = word[TICK_W-1:0];
            CFG_START_POSITION:
            begin
                start_reg = word[POS_W-1:0];
                load_start_position();
            end
            default: ;
        endcase
        n_writes++;
        @(posedge clk);
        cfg_en <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin : stall_driver
        int hold;
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            hold = draw_gap();
            out_stall <= (hold != 0);
            stall_left = (hold != 0) ? hold - 1 : 0;
        end
    end

    always @(negedge clk)
    begin : check_outputs
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outputs.size() == 0)
            begin
                report_mismatch("transfer with no pending output");
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (out_data.position_valid !== want.position_valid)
                begin
                    report_mismatch($sformatf("position_valid got %0b want %0b",
                                              out_data.position_valid, want.position_valid));
                end
                if (out_data.seek_position !== want.seek_position)
                begin
                    report_mismatch($sformatf("seek_position got %0d want %0d",
                                              out_data.seek_position, want.seek_position));
                end
                if (out_data.drive_enabled !== want.drive_enabled)
                begin
                    report_mismatch($sformatf("drive_enabled got %0b want %0b",
                                              out_data.drive_enabled, want.drive_enabled));
                end
                if (out_data.pulse_rejected !== want.pulse_rejected)
                begin
                    report_mismatch($sformatf("pulse_rejected got %0b want %0b",
                                              out_data.pulse_rejected, want.pulse_rejected));
                end
            end
            n_outputs++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: timeout after %0d cycles", cycle_count);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        row_t plan[$];
        row_t r;
        int ph, done, pick, hi, lo, cap, len, j;
        int p_min_d, p_max_d, p_min_p, p_max_p, p_shift, p_tmo, p_start;

        dur_lo = RST_MIN_DURATION;
        dur_hi = RST_MAX_DURATION;
        pos_lo = RST_MIN_POSITION;
        pos_hi = RST_MAX_POSITION;
        shift_reg = RST_FILTER_SHIFT;
        tmo_reg = RST_TIMEOUT_TICKS;
        start_reg = RST_START_POSITION;
        pulse_len = '0;
        in_pulse = 1'b0;
        last_pin = 1'b0;
        idle_cnt = '0;
        drive = 1'b0;
        load_start_position();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // A pin already high on the first sample after reset starts a pulse.
        plan.push_back(checked_row(1'b1, 1'b0, 1, 1'b0, 3022, 1'b0, 1'b0));
        plan.push_back(checked_row(1'b0, 1'b0, 1, 1'b0, 3022, 1'b0, 1'b1));
        plan.push_back(write_row(CFG_MIN_DURATION, 2));
        plan.push_back(write_row(CFG_MAX_DURATION, 9));
        plan.push_back(write_row(CFG_MIN_POSITION, 4));
        plan.push_back(write_row(CFG_MAX_POSITION, 8));
        plan.push_back(sample_row(1'b1, 1'b0, 3));
        plan.push_back(sample_row(1'b0, 1'b0, 1));
        plan.push_back(sample_row(1'b1, 1'b0, 8));
        plan.push_back(sample_row(1'b0, 1'b0, 1));
        plan.push_back(sample_row(1'b1, 1'b0, 9));
        plan.push_back(sample_row(1'b0, 1'b0, 1));
        plan.push_back(sample_row(1'b1, 1'b0, 2));
        plan.push_back(sample_row(1'b0, 1'b0, 1));
        // With a zero shift the filter passes the clamped position through.
        plan.push_back(write_row(CFG_FILTER_SHIFT, 0));
        plan.push_back(sample_row(1'b1, 1'b0, 5));
        plan.push_back(checked_row(1'b0, 1'b0, 1, 1'b1, 5, 1'b1, 1'b0));
        plan.push_back(write_row(CFG_FILTER_SHIFT, 15));
        plan.push_back(write_row(CFG_START_POSITION, 16383));
        plan.push_back(sample_row(1'b1, 1'b0, 5));
        plan.push_back(sample_row(1'b0, 1'b0, 1));
        // Crossed clamp limits resolve to the upper limit.
        plan.push_back(write_row(CFG_FILTER_SHIFT, 0));
        plan.push_back(write_row(CFG_MIN_POSITION, 8));
        plan.push_back(write_row(CFG_MAX_POSITION, 4));
        plan.push_back(sample_row(1'b1, 1'b0, 6));
        plan.push_back(checked_row(1'b0, 1'b0, 1, 1'b1, 4, 1'b1, 1'b0));
        plan.push_back(write_row(CFG_TIMEOUT_TICKS, 0));
        plan.push_back(checked_row(1'b0, 1'b1, 1, 1'b0, 4, 1'b0, 1'b0));
        // The largest timeout never expires because the tick count saturates.
        plan.push_back(write_row(CFG_TIMEOUT_TICKS, 255));
        plan.push_back(sample_row(1'b1, 1'b0, 6));
        plan.push_back(checked_row(1'b0, 1'b0, 1, 1'b1, 4, 1'b1, 1'b0));
        plan.push_back(checked_row(1'b0, 1'b1, 300, 1'b0, 4, 1'b1, 1'b0));
        // A tick on the step where a rejected pulse ends is counted but not checked.
        plan.push_back(write_row(CFG_TIMEOUT_TICKS, 0));
        plan.push_back(sample_row(1'b1, 1'b0, 6));
        plan.push_back(checked_row(1'b0, 1'b0, 1, 1'b1, 4, 1'b1, 1'b0));
        plan.push_back(sample_row(1'b1, 1'b0, 2));
        plan.push_back(checked_row(1'b0, 1'b1, 1, 1'b0, 4, 1'b1, 1'b1));
        plan.push_back(checked_row(1'b0, 1'b0, 1, 1'b0, 4, 1'b0, 1'b0));
        // An empty window rejects every pulse.
        plan.push_back(write_row(CFG_MIN_DURATION, 5));
        plan.push_back(write_row(CFG_MAX_DURATION, 6));
        plan.push_back(sample_row(1'b1, 1'b0, 5));
        plan.push_back(checked_row(1'b0, 1'b0, 1, 1'b0, 4, 1'b0, 1'b1));
        plan.push_back(sample_row(1'b1, 1'b0, 6));
        plan.push_back(checked_row(1'b0, 1'b0, 1, 1'b0, 4, 1'b0, 1'b1));

        foreach (plan[r_i])
        begin
            r = plan[r_i];
            if (r.kind == ROW_WRITE)
            begin
                drain_outputs();
                write_reg(r.reg_idx, r.reg_val);
            end
            else
            begin
                idle_on = (r.reps < 1000);
                repeat (r.reps) send_sample(r.pin, r.tick, r.fixed, r.lit);
            end
        end

        for (ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0:
                begin
                    p_min_d = 0;
                    p_max_d = 65535;
                    p_min_p = 0;
                    p_max_p = 16383;
                    p_shift = 8;
                    p_tmo = 255;
                    p_start = 16383;
                end
                6:
                begin
                    p_min_d = 0;
                    p_max_d = 0;
                    p_min_p = 0;
                    p_max_p = 0;
                    p_shift = 0;
                    p_tmo = 0;
                    p_start = 0;
                end
                default:
                begin
                    p_min_d = $urandom_range(0, 12);
                    p_max_d = p_min_d + $urandom_range(0, 30);
                    p_min_p = $urandom_range(0, 30);
                    p_max_p = ($urandom_range(0, 3) == 0) ? 16383 : $urandom_range(0, 50);
                    p_shift = $urandom_range(0, 15);
                    p_tmo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 12);
                    p_start = $urandom_range(0, 16383);
                end
            endcase
            idle_on = 1'b1;
            drain_outputs();
            write_reg(CFG_MIN_DURATION, p_min_d);
            write_reg(CFG_MAX_DURATION, p_max_d);
            write_reg(CFG_MIN_POSITION, p_min_p);
            write_reg(CFG_MAX_POSITION, p_max_p);
            write_reg(CFG_FILTER_SHIFT, p_shift);
            write_reg(CFG_TIMEOUT_TICKS, p_tmo);
            write_reg(CFG_START_POSITION, p_start);
            idle_on = (ph != 3);
            cap = (p_max_d > 56) ? 60 : p_max_d + 4;
            done = 0;
            while (done < 90)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                begin
                    drain_outputs();
                end
                if (pick < 75)
                begin
                    hi = $urandom_range(1, cap);
                    lo = $urandom_range(1, 6);
                    for (j = 0; j < hi; j++)
                    begin
                        send_sample(1'b1, $urandom_range(0, 7) == 0, 1'b0, '0);
                    end
                    for (j = 0; j < lo; j++)
                    begin
                        send_sample(1'b0, $urandom_range(0, 7) == 0, 1'b0, '0);
                    end
                    done += hi + lo;
                end
                else if (pick < 90)
                begin
                    len = $urandom_range(1, 6);
                    for (j = 0; j < len; j++)
                    begin
                        send_sample($urandom_range(0, 1) == 1, $urandom_range(0, 7) == 0,
                                    1'b0, '0);
                    end
                    done += len;
                end
                else
                begin
                    len = $urandom_range(10, 60);
                    for (j = 0; j < len; j++)
                    begin
                        send_sample(1'b0, $urandom_range(0, 2) == 0, 1'b0, '0);
                    end
                    done += len;
                end
            end
        end

        idle_on = 1'b1;
        drain_outputs();
        repeat (8) @(posedge clk);

        $display("tb_top: %0d samples, %0d outputs checked, %0d register writes",
                 n_samples, n_outputs, n_writes);
        $display("tb_top: %0d positions accepted, %0d pulses rejected, %0d drive timeouts",
                 n_positions, n_rejects, n_drops);
        if (n_errors == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/sppd_pkg.sv
rtl/servo_pulse_position_decoder_unit.sv
tb/sv/tb_top.sv
